>>> sv/gap_pkg.sv
// ----------------------------------------------------------------------------
// Global average pool package
// Shared constants and types for the global average pooling core: default
// sizes, the back-end state encoding and the queue status bundle.
// ----------------------------------------------------------------------------
package gap_pkg;

  // Width of the pool size write port.
  localparam int unsigned CFG_W = 13;

  // Defaults for the top-level parameters.
  localparam int unsigned DEF_MAX_POOL_SIZE = 4096;
  localparam int unsigned DEF_SAMPLE_WIDTH  = 16;

  // Number of closed channels that can wait between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_HOLD
  } bk_state_e;

  // Fill status of the channel queue.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> sv/global_average_pool_core.sv
// ----------------------------------------------------------------------------
// Global average pooling core
// Streams signed Q8.8 samples channel by channel and returns each channel's
// mean, truncated toward zero and saturated to the sample range.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle as long as the two-entry channel queue has
// room. Each closed channel is divided by a restoring divider that produces
// one quotient bit per cycle over a SUM_W-bit dividend, where
// SUM_W = SAMPLE_WIDTH + clog2(MAX_POOL_SIZE) + 1; the front stalls only when
// the queue is full, as when channels close faster than the back end divides
// them or the output is held back. A pool size of zero acts as one, sizes
// above MAX_POOL_SIZE clamp to it, and a write takes effect at once while the
// running sum and count are kept.
module global_average_pool_core #(
  parameter int unsigned MAX_POOL_SIZE = gap_pkg::DEF_MAX_POOL_SIZE,
  parameter int unsigned SAMPLE_WIDTH  = gap_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           pool_size_we_i,
  input  logic [gap_pkg::CFG_W-1:0]      pool_size_i,
  input  logic                           sample_valid_i,
  output logic                           sample_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  output logic                           average_valid_o,
  input  logic                           average_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] average_o
);

  localparam int unsigned CNT_W = (MAX_POOL_SIZE > 1) ? $clog2(MAX_POOL_SIZE) : 1;
  localparam int unsigned N_W   = $clog2(MAX_POOL_SIZE + 1);
  localparam int unsigned SUM_W = SAMPLE_WIDTH + CNT_W + 1;

  gap_pkg::q_status_t q_status;
  logic               push, pop;
  logic [SUM_W-1:0]   push_sum;
  logic [N_W-1:0]     push_size;
  logic [SUM_W+N_W-1:0] pop_data;

  // Front end: configuration and accumulation.
  gap_front #(
    .MAX_POOL_SIZE (MAX_POOL_SIZE),
    .SAMPLE_WIDTH  (SAMPLE_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pool_size_we_i (pool_size_we_i),
    .pool_size_i    (pool_size_i),
    .sample_valid_i (sample_valid_i),
    .sample_ready_o (sample_ready_o),
    .sample_i       (sample_i),
    .q_status_i     (q_status),
    .push_o         (push),
    .push_sum_o     (push_sum),
    .push_size_o    (push_size)
  );

  // Queue of closed channels.
  gap_queue #(
    .DATA_W (SUM_W + N_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_sum, push_size}),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  // Back end: division and output register.
  gap_back #(
    .MAX_POOL_SIZE (MAX_POOL_SIZE),
    .SAMPLE_WIDTH  (SAMPLE_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_status_i      (q_status),
    .q_sum_i         (pop_data[SUM_W+N_W-1:N_W]),
    .q_size_i        (pop_data[N_W-1:0]),
    .pop_o           (pop),
    .average_valid_o (average_valid_o),
    .average_ready_i (average_ready_i),
    .average_o       (average_o)
  );

endmodule

>>> sv/gap_front.sv
// ----------------------------------------------------------------------------
// Global average pool front end
// Holds the pool size register, accepts samples, keeps the running channel
// sum and sample count, and pushes each closed channel's sum and size into
// the channel queue.
// ----------------------------------------------------------------------------
module gap_front #(
  parameter int unsigned MAX_POOL_SIZE = gap_pkg::DEF_MAX_POOL_SIZE,
  parameter int unsigned SAMPLE_WIDTH  = gap_pkg::DEF_SAMPLE_WIDTH,
  localparam int unsigned CNT_W = (MAX_POOL_SIZE > 1) ? $clog2(MAX_POOL_SIZE) : 1,
  localparam int unsigned N_W   = $clog2(MAX_POOL_SIZE + 1),
  localparam int unsigned SUM_W = SAMPLE_WIDTH + CNT_W + 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           pool_size_we_i,
  input  logic [gap_pkg::CFG_W-1:0]      pool_size_i,
  input  logic                           sample_valid_i,
  output logic                           sample_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  gap_pkg::q_status_t             q_status_i,
  output logic                           push_o,
  output logic [SUM_W-1:0]               push_sum_o,
  output logic [N_W-1:0]                 push_size_o
);

  logic [N_W-1:0]   size_q, size_d;
  logic [SUM_W-1:0] sum_q, sum_d, sum_next;
  logic [CNT_W-1:0] count_q, count_d;
  logic [N_W:0]     count_inc;
  logic [31:0]      ps32, eff32;
  logic             accept, close;

  // Effective pool size: zero acts as one, large values clamp to the maximum.
  always_comb begin
    ps32 = 32'(pool_size_i);
    if (ps32 == 32'd0) begin
      eff32 = 32'd1;
    end else if (ps32 > 32'(MAX_POOL_SIZE)) begin
      eff32 = 32'(MAX_POOL_SIZE);
    end else begin
      eff32 = ps32;
    end
    size_d = pool_size_we_i ? N_W'(eff32) : size_q;
  end

  // A sample is taken whenever the queue has room for a closing channel.
  assign sample_ready_o = !q_status_i.full;
  assign accept         = sample_valid_i && sample_ready_o;

  // Running sum and count; the channel closes when the count reaches the size.
  always_comb begin
    sum_next  = sum_q + {{(SUM_W - SAMPLE_WIDTH){sample_i[SAMPLE_WIDTH-1]}}, sample_i};
    count_inc = {{(N_W + 1 - CNT_W){1'b0}}, count_q} + (N_W + 1)'(1);
    close     = count_inc >= {1'b0, size_q};
    sum_d     = sum_q;
    count_d   = count_q;
    if (accept) begin
      if (close) begin
        sum_d   = '0;
        count_d = '0;
      end else begin
        sum_d   = sum_next;
        count_d = count_inc[CNT_W-1:0];
      end
    end
  end

  assign push_o      = accept && close;
  assign push_sum_o  = sum_next;
  assign push_size_o = size_q;

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= N_W'(1);
      sum_q   <= '0;
      count_q <= '0;
    end else begin
      size_q  <= size_d;
      sum_q   <= sum_d;
      count_q <= count_d;
    end
  end

  // A closing request always leaves the channel cleared.
  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (count_q == '0) && (sum_q == '0))
    else $error("channel state not cleared after close");

endmodule

>>> sv/gap_queue.sv
// ----------------------------------------------------------------------------
// Global average pool channel queue
// A short first-in first-out buffer of closed channels (sum and size) that
// lets the front end and the divider stall independently.
// ----------------------------------------------------------------------------
module gap_queue #(
  parameter int unsigned DATA_W = 42,
  localparam int unsigned PTR_W = (gap_pkg::QUEUE_DEPTH > 1) ? $clog2(gap_pkg::QUEUE_DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(gap_pkg::QUEUE_DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [DATA_W-1:0]  push_data_i,
  input  logic               pop_i,
  output logic [DATA_W-1:0]  pop_data_o,
  output gap_pkg::q_status_t status_o
);

  logic [DATA_W-1:0] mem_q [gap_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign status_o.full  = (count_q == CNT_W'(gap_pkg::QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign pop_data_o     = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(gap_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(gap_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // The fill count never runs past the depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(gap_pkg::QUEUE_DEPTH))
    else $error("queue fill count out of range");

endmodule

>>> sv/gap_back.sv
// ----------------------------------------------------------------------------
// Global average pool back end
// Takes closed channels from the queue, divides the sum by the pool size with
// a one-bit-per-cycle restoring divider, truncates toward zero, saturates to
// the sample range and holds the average in the output register.
// ----------------------------------------------------------------------------
module gap_back #(
  parameter int unsigned MAX_POOL_SIZE = gap_pkg::DEF_MAX_POOL_SIZE,
  parameter int unsigned SAMPLE_WIDTH  = gap_pkg::DEF_SAMPLE_WIDTH,
  localparam int unsigned CNT_W = (MAX_POOL_SIZE > 1) ? $clog2(MAX_POOL_SIZE) : 1,
  localparam int unsigned N_W   = $clog2(MAX_POOL_SIZE + 1),
  localparam int unsigned SUM_W = SAMPLE_WIDTH + CNT_W + 1,
  localparam int unsigned BC_W  = $clog2(SUM_W)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gap_pkg::q_status_t             q_status_i,
  input  logic [SUM_W-1:0]               q_sum_i,
  input  logic [N_W-1:0]                 q_size_i,
  output logic                           pop_o,
  output logic                           average_valid_o,
  input  logic                           average_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] average_o
);

  localparam logic [SUM_W-1:0] MAG_HI =
    {{(SUM_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic [SUM_W-1:0] MAG_LO =
    {{(SUM_W - SAMPLE_WIDTH){1'b0}}, 1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

  gap_pkg::bk_state_e state_q, state_d;
  logic [N_W-1:0]          rem_q, rem_d, div_q, div_d;
  logic [SUM_W-1:0]        quo_q, quo_d, quo_neg;
  logic [BC_W-1:0]         bcnt_q, bcnt_d;
  logic                    neg_q, neg_d;
  logic [N_W:0]            trial, diff;
  logic                    ge, out_free, out_load, out_valid_q;
  logic [SAMPLE_WIDTH-1:0] avg_sat, out_q;

  assign out_free = !out_valid_q || average_ready_i;

  // One restoring division step.
  always_comb begin
    trial = {rem_q, quo_q[SUM_W-1]};
    ge    = trial >= {1'b0, div_q};
    diff  = trial - {1'b0, div_q};
  end

  // Sequencer: load a channel, divide, then hand the result to the output.
  always_comb begin
    state_d  = state_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    div_d    = div_q;
    neg_d    = neg_q;
    bcnt_d   = bcnt_q;
    pop_o    = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      gap_pkg::BK_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o   = 1'b1;
          neg_d   = q_sum_i[SUM_W-1];
          quo_d   = q_sum_i[SUM_W-1] ? ('0 - q_sum_i) : q_sum_i;
          rem_d   = '0;
          div_d   = q_size_i;
          bcnt_d  = BC_W'(SUM_W - 1);
          state_d = gap_pkg::BK_DIV;
        end
      end
      gap_pkg::BK_DIV: begin
        rem_d  = ge ? diff[N_W-1:0] : trial[N_W-1:0];
        quo_d  = {quo_q[SUM_W-2:0], ge};
        bcnt_d = bcnt_q - 1'b1;
        if (bcnt_q == '0) begin
          state_d = gap_pkg::BK_HOLD;
        end
      end
      gap_pkg::BK_HOLD: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = gap_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = gap_pkg::BK_IDLE;
      end
    endcase
  end

  // Apply the sign and clamp the quotient magnitude to the sample range.
  always_comb begin
    quo_neg = '0 - quo_q;
    if (neg_q) begin
      avg_sat = (quo_q > MAG_LO) ? MAG_LO[SAMPLE_WIDTH-1:0] : quo_neg[SAMPLE_WIDTH-1:0];
    end else begin
      avg_sat = (quo_q > MAG_HI) ? MAG_HI[SAMPLE_WIDTH-1:0] : quo_q[SAMPLE_WIDTH-1:0];
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gap_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (average_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    div_q  <= div_d;
    neg_q  <= neg_d;
    bcnt_q <= bcnt_d;
    if (out_load) begin
      out_q <= avg_sat;
    end
  end

  assign average_valid_o = out_valid_q;
  assign average_o       = out_q;

  // The partial remainder stays below the divisor throughout the division.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gap_pkg::BK_DIV) |-> (rem_q < div_q))
    else $error("divider remainder not below divisor");

  // A finished division always lands in the output register.
  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> average_valid_o)
    else $error("finished result not presented");

  // Nothing is popped while a result is still in flight.
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == gap_pkg::BK_IDLE) && !q_status_i.empty)
    else $error("queue popped outside idle");

endmodule
